FILE: sv/assert_macros.svh
// assertion macros for the placer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define RGRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define RGRP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: sv/rgrp_pkg.sv
// types and constants of the reserved gap region placer
package rgrp_pkg;

    localparam int unsigned KIND_BITS    = 8;
    localparam logic [KIND_BITS-1:0] KIND_USABLE = 8'd1;

    localparam int unsigned CFG_IDX_BITS = 3;

    // reset values of the size and low limit registers
    localparam int unsigned REQUEST_SIZE_RST = 4096;
    localparam int unsigned LOW_LIMIT_RST    = 1024 * 1024;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_KERNEL_FIRST    = 3'd0,
        CFG_KERNEL_LAST     = 3'd1,
        CFG_BOOT_INFO_FIRST = 3'd2,
        CFG_BOOT_INFO_LAST  = 3'd3,
        CFG_REQUEST_SIZE    = 3'd4,
        CFG_LOW_LIMIT       = 3'd5
    } rgrp_cfg_idx_t;

    // per-region flags after gap clipping
    typedef struct packed {
        logic cand;   // usable, non-empty, ends at or above the low limit
        logic hk;     // kernel range overlaps the region
        logic hb;     // boot-info range overlaps the region
        logic last;   // final region of the map
    } rgrp_gap_flags_t;

    // per-region placement outcome
    typedef struct packed {
        logic found;
        logic last;
    } rgrp_hit_t;

endpackage

FILE: sv/rgrp_gaps.sv
// input register, region end and clipping of the two reserved ranges
module rgrp_gaps import rgrp_pkg::*; #(
    parameter int ADDR_BITS = 52
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ADDR_BITS-1:0] s_region_base,
    input  logic [ADDR_BITS-1:0] s_region_length,
    input  logic [KIND_BITS-1:0] s_region_kind,
    input  logic                 s_last_region,
    input  logic [ADDR_BITS-1:0] kernel_first,
    input  logic [ADDR_BITS-1:0] kernel_last,
    input  logic [ADDR_BITS-1:0] boot_info_first,
    input  logic [ADDR_BITS-1:0] boot_info_last,
    input  logic [ADDR_BITS-1:0] low_limit,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rgrp_gap_flags_t      out_flags,
    output logic [ADDR_BITS-1:0] out_start,
    output logic [ADDR_BITS-1:0] out_end,
    output logic [ADDR_BITS-1:0] out_kfirst,
    output logic [ADDR_BITS-1:0] out_klast,
    output logic [ADDR_BITS-1:0] out_bfirst,
    output logic [ADDR_BITS-1:0] out_blast
);

    localparam logic [ADDR_BITS-1:0] AMAX = '1;

    // stage a: input register
    logic                 a_valid_reg;
    logic [ADDR_BITS-1:0] a_base_reg;
    logic [ADDR_BITS-1:0] a_len_reg;
    logic [KIND_BITS-1:0] a_kind_reg;
    logic                 a_last_reg;
    // stage b: region bounds
    logic                 b_valid_reg;
    logic [ADDR_BITS-1:0] b_start_reg;
    logic [ADDR_BITS-1:0] b_end_reg;
    logic                 b_use_reg;
    logic                 b_last_reg;
    // stage c: clipped gaps
    logic                 c_valid_reg;
    rgrp_gap_flags_t      c_flags_reg;
    logic [ADDR_BITS-1:0] c_start_reg;
    logic [ADDR_BITS-1:0] c_end_reg;
    logic [ADDR_BITS-1:0] c_kfirst_reg;
    logic [ADDR_BITS-1:0] c_klast_reg;
    logic [ADDR_BITS-1:0] c_bfirst_reg;
    logic [ADDR_BITS-1:0] c_blast_reg;

    logic a_ready, b_ready, c_ready;

    assign c_ready = !c_valid_reg || out_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_valid) begin
            a_base_reg <= s_region_base;
            a_len_reg  <= s_region_length;
            a_kind_reg <= s_region_kind;
            a_last_reg <= s_last_region;
        end
    end

    // inclusive end, saturated at the top address
    logic [ADDR_BITS-1:0] len_m1;
    logic [ADDR_BITS:0]   end_sum;
    logic [ADDR_BITS-1:0] end_next;
    logic                 use_next;

    always_comb begin
        len_m1   = a_len_reg - ADDR_BITS'(1);
        end_sum  = {1'b0, a_base_reg} + {1'b0, len_m1};
        end_next = end_sum[ADDR_BITS] ? AMAX : end_sum[ADDR_BITS-1:0];
        use_next = (a_kind_reg == KIND_USABLE) && (a_len_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_start_reg <= a_base_reg;
            b_end_reg   <= end_next;
            b_use_reg   <= use_next;
            b_last_reg  <= a_last_reg;
        end
    end

    // overlap tests and clipping to the region, both ranges in parallel
    rgrp_gap_flags_t      flags_next;
    logic [ADDR_BITS-1:0] kfirst_next, klast_next, bfirst_next, blast_next;

    always_comb begin
        flags_next.cand = b_use_reg && (b_end_reg >= low_limit);
        flags_next.hk   = (kernel_first <= kernel_last) && (kernel_first <= b_end_reg)
                          && (b_start_reg <= kernel_last);
        flags_next.hb   = (boot_info_first <= boot_info_last)
                          && (boot_info_first <= b_end_reg)
                          && (b_start_reg <= boot_info_last);
        flags_next.last = b_last_reg;
        kfirst_next = (kernel_first < b_start_reg) ? b_start_reg : kernel_first;
        klast_next  = (kernel_last > b_end_reg) ? b_end_reg : kernel_last;
        bfirst_next = (boot_info_first < b_start_reg) ? b_start_reg : boot_info_first;
        blast_next  = (boot_info_last > b_end_reg) ? b_end_reg : boot_info_last;
    end

    always_ff @(posedge aclk) begin
        if (c_ready && b_valid_reg) begin
            c_flags_reg  <= flags_next;
            c_start_reg  <= b_start_reg;
            c_end_reg    <= b_end_reg;
            c_kfirst_reg <= kfirst_next;
            c_klast_reg  <= klast_next;
            c_bfirst_reg <= bfirst_next;
            c_blast_reg  <= blast_next;
        end
    end

    assign out_valid  = c_valid_reg;
    assign out_flags  = c_flags_reg;
    assign out_start  = c_start_reg;
    assign out_end    = c_end_reg;
    assign out_kfirst = c_kfirst_reg;
    assign out_klast  = c_klast_reg;
    assign out_bfirst = c_bfirst_reg;
    assign out_blast  = c_blast_reg;

endmodule

FILE: sv/rgrp_piece.sv
// fit test of one inclusive piece with the start aligned up to a frame
module rgrp_piece import rgrp_pkg::*; #(
    parameter int ADDR_BITS   = 52,
    parameter int FRAME_SHIFT = 12
) (
    input  logic [ADDR_BITS-1:0] lo,
    input  logic [ADDR_BITS-1:0] hi,
    input  logic                 ok,
    input  logic [ADDR_BITS-1:0] req_size,
    output logic                 fit,
    output logic [ADDR_BITS-1:0] addr
);

    localparam logic [ADDR_BITS-1:0] FMASK =
        {{(ADDR_BITS-FRAME_SHIFT){1'b0}}, {FRAME_SHIFT{1'b1}}};
    localparam logic [ADDR_BITS:0] FRAME =
        {{(ADDR_BITS-FRAME_SHIFT){1'b0}}, 1'b1, {FRAME_SHIFT{1'b0}}};

    logic [ADDR_BITS-1:0] a_down;
    logic [ADDR_BITS:0]   a_up;
    logic                 frac;
    logic                 a_ovf;
    logic [ADDR_BITS-1:0] span;
    logic [ADDR_BITS-1:0] req_m1;

    always_comb begin
        a_down = lo & ~FMASK;
        a_up   = {1'b0, a_down} + FRAME;
        frac   = |lo[FRAME_SHIFT-1:0];
        addr   = frac ? a_up[ADDR_BITS-1:0] : a_down;
        // rounding up past the top address
        a_ovf  = frac && a_up[ADDR_BITS];
        span   = hi - addr;
        req_m1 = req_size - ADDR_BITS'(1);
        fit    = ok && (req_size != '0) && !a_ovf && (addr <= hi) && (span >= req_m1);
    end

endmodule

FILE: sv/rgrp_fit.sv
// piece bounds from the sorted gaps, then the three fit tests in priority
module rgrp_fit import rgrp_pkg::*; #(
    parameter int ADDR_BITS   = 52,
    parameter int FRAME_SHIFT = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rgrp_gap_flags_t      in_flags,
    input  logic [ADDR_BITS-1:0] in_start,
    input  logic [ADDR_BITS-1:0] in_end,
    input  logic [ADDR_BITS-1:0] in_kfirst,
    input  logic [ADDR_BITS-1:0] in_klast,
    input  logic [ADDR_BITS-1:0] in_bfirst,
    input  logic [ADDR_BITS-1:0] in_blast,
    input  logic [ADDR_BITS-1:0] req_size,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rgrp_hit_t            out_hit,
    output logic [ADDR_BITS-1:0] out_addr
);

    localparam logic [ADDR_BITS-1:0] AMAX = '1;

    // stage d: piece bounds
    logic                 d_valid_reg;
    logic                 d_cand_reg;
    logic                 d_last_reg;
    logic [ADDR_BITS-1:0] d_lo_reg [3];
    logic [ADDR_BITS-1:0] d_hi_reg [3];
    logic [2:0]           d_ok_reg;
    // stage e: chosen start of this region
    logic                 e_valid_reg;
    rgrp_hit_t            e_hit_reg;
    logic [ADDR_BITS-1:0] e_addr_reg;

    logic d_ready, e_ready;

    assign e_ready  = !e_valid_reg || out_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign in_ready = d_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (d_ready) begin
                d_valid_reg <= in_valid;
            end
            if (e_ready) begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    // gap selection: both ranges, or the one that overlaps taken twice
    logic [ADDR_BITS-1:0] g1s, g1e, g2s, g2e;
    logic [ADDR_BITS-1:0] ls, le, hs, he, top;
    logic                 swap, gap, both;
    logic [ADDR_BITS-1:0] lo_next [3];
    logic [ADDR_BITS-1:0] hi_next [3];
    logic [2:0]           ok_next;

    always_comb begin
        g1s  = in_flags.hk ? in_kfirst : in_bfirst;
        g1e  = in_flags.hk ? in_klast  : in_blast;
        g2s  = in_flags.hb ? in_bfirst : in_kfirst;
        g2e  = in_flags.hb ? in_blast  : in_klast;
        swap = g1s > g2s;
        ls   = swap ? g2s : g1s;
        le   = swap ? g2e : g1e;
        hs   = swap ? g1s : g2s;
        he   = swap ? g1e : g2e;
        // nested gaps: the upper piece starts past the higher end
        top  = (le > he) ? le : he;
        gap  = in_flags.hk || in_flags.hb;
        both = in_flags.hk && in_flags.hb;

        lo_next[0] = in_start;
        hi_next[0] = gap ? ls - ADDR_BITS'(1) : in_end;
        ok_next[0] = gap ? (ls != '0) : 1'b1;

        lo_next[1] = le + ADDR_BITS'(1);
        hi_next[1] = hs - ADDR_BITS'(1);
        ok_next[1] = both && (le != AMAX) && (hs != '0);

        lo_next[2] = top + ADDR_BITS'(1);
        hi_next[2] = in_end;
        ok_next[2] = gap && (top != AMAX);
    end

    always_ff @(posedge aclk) begin
        if (d_ready && in_valid) begin
            d_cand_reg <= in_flags.cand;
            d_last_reg <= in_flags.last;
            d_ok_reg   <= ok_next;
            for (int i = 0; i < 3; i++) begin
                d_lo_reg[i] <= lo_next[i];
                d_hi_reg[i] <= hi_next[i];
            end
        end
    end

    logic [2:0]           fit;
    logic [ADDR_BITS-1:0] fit_addr [3];

    for (genvar g = 0; g < 3; g++) begin : g_piece
        rgrp_piece #(
            .ADDR_BITS  (ADDR_BITS),
            .FRAME_SHIFT(FRAME_SHIFT)
        ) u_piece (
            .lo      (d_lo_reg[g]),
            .hi      (d_hi_reg[g]),
            .ok      (d_ok_reg[g]),
            .req_size(req_size),
            .fit     (fit[g]),
            .addr    (fit_addr[g])
        );
    end

    rgrp_hit_t            hit_next;
    logic [ADDR_BITS-1:0] addr_next;

    always_comb begin
        hit_next.found = d_cand_reg && (|fit);
        hit_next.last  = d_last_reg;
        if (fit[0]) begin
            addr_next = fit_addr[0];
        end else if (fit[1]) begin
            addr_next = fit_addr[1];
        end else begin
            addr_next = fit_addr[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (e_ready && d_valid_reg) begin
            e_hit_reg  <= hit_next;
            e_addr_reg <= addr_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_hit   = e_hit_reg;
    assign out_addr  = e_addr_reg;

endmodule

FILE: sv/rgrp_report.sv
// latch of the first placement and the result register
`include "assert_macros.svh"

module rgrp_report import rgrp_pkg::*; #(
    parameter int ADDR_BITS   = 52,
    parameter int FRAME_SHIFT = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rgrp_hit_t            in_hit,
    input  logic [ADDR_BITS-1:0] in_addr,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_place_found,
    output logic [ADDR_BITS-1:0] m_place_address
);

    logic                 have_reg, have_next;
    logic [ADDR_BITS-1:0] chosen_reg, chosen_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_found_reg;
    logic [ADDR_BITS-1:0] m_addr_reg;

    logic                 take;
    logic                 now_have;
    logic [ADDR_BITS-1:0] now_addr;

    // only the final region needs a free result register
    assign in_ready = !in_hit.last || !m_valid_reg || m_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        now_have    = have_reg || in_hit.found;
        now_addr    = have_reg ? chosen_reg : in_addr;
        have_next   = have_reg;
        chosen_next = chosen_reg;
        if (take) begin
            have_next   = in_hit.last ? 1'b0 : now_have;
            chosen_next = now_addr;
        end
        m_valid_next = m_valid_reg && !m_ready;
        if (take && in_hit.last) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            have_reg    <= have_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chosen_reg <= chosen_next;
        if (take && in_hit.last) begin
            m_found_reg <= now_have;
            m_addr_reg  <= now_have ? now_addr : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_place_found   = m_found_reg;
    assign m_place_address = m_addr_reg;

    `RGRP_ASSERT_RST(a_reset_clears, !aresetn |=> (!m_valid_reg && !have_reg), "reset left state")
    `RGRP_ASSERT(a_clear_after_last, (take && in_hit.last) |=> !have_reg, "place kept past map end")
    `RGRP_ASSERT(a_rise_on_last, $rose(m_valid_reg) |-> $past(take && in_hit.last), "stray result")
    `RGRP_ASSERT(a_zero_if_none, m_valid_reg |-> (m_found_reg || m_addr_reg == '0), "address not zero")
    `RGRP_ASSERT(a_aligned, have_reg |-> (chosen_reg[FRAME_SHIFT-1:0] == '0), "start not aligned")

endmodule

FILE: sv/reserved_gap_region_placer.sv
// top level of the reserved gap region placer
//
// usage: memory-map regions enter one word at a time on the s_ channel
// (valid/ready); the word that carries s_last_region closes a map and
// produces one result word on the m_ channel: m_place_found and the
// frame-aligned m_place_address (zero when nothing fits). words without
// s_last_region produce nothing.
// configuration: cfg_wen/cfg_idx/cfg_wdata write the kernel range, the
// boot-info range, the request size and the low limit; the user must
// write them only while idle, the block does not enforce it.
// throughput: one region per cycle unless a final region waits on the
// held result register; the pipeline has no loop. the final region
// passes the input, end, clip, bounds, fit and result registers.
// reset (aresetn low, synchronous): pipeline emptied, placement latch
// cleared, registers back to their defaults (size 4096, limit 1 MiB).
// stall: the result register holds while m_ready is low; regions keep
// flowing into the pipe and only a following final region waits.
module reserved_gap_region_placer import rgrp_pkg::*; #(
    parameter int ADDR_BITS   = 52,
    parameter int FRAME_SHIFT = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // region words
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ADDR_BITS-1:0]    s_region_base,
    input  logic [ADDR_BITS-1:0]    s_region_length,
    input  logic [KIND_BITS-1:0]    s_region_kind,
    input  logic                    s_last_region,
    // result words
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_place_found,
    output logic [ADDR_BITS-1:0]    m_place_address,
    // register writes
    input  logic                    cfg_wen,
    input  logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [ADDR_BITS-1:0]    cfg_wdata
);

    // configuration registers
    logic [ADDR_BITS-1:0] kernel_first_reg;
    logic [ADDR_BITS-1:0] kernel_last_reg;
    logic [ADDR_BITS-1:0] boot_info_first_reg;
    logic [ADDR_BITS-1:0] boot_info_last_reg;
    logic [ADDR_BITS-1:0] request_size_reg;
    logic [ADDR_BITS-1:0] low_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_first_reg    <= '0;
            kernel_last_reg     <= '0;
            boot_info_first_reg <= '0;
            boot_info_last_reg  <= '0;
            request_size_reg    <= ADDR_BITS'(REQUEST_SIZE_RST);
            low_limit_reg       <= ADDR_BITS'(LOW_LIMIT_RST);
        end else if (cfg_wen) begin
            case (cfg_idx)
                CFG_KERNEL_FIRST:    kernel_first_reg    <= cfg_wdata;
                CFG_KERNEL_LAST:     kernel_last_reg     <= cfg_wdata;
                CFG_BOOT_INFO_FIRST: boot_info_first_reg <= cfg_wdata;
                CFG_BOOT_INFO_LAST:  boot_info_last_reg  <= cfg_wdata;
                CFG_REQUEST_SIZE:    request_size_reg    <= cfg_wdata;
                CFG_LOW_LIMIT:       low_limit_reg       <= cfg_wdata;
                default: begin
                    // unused indexes are dropped
                end
            endcase
        end
    end

    // gaps -> fit
    logic                 gap_valid, gap_ready;
    rgrp_gap_flags_t      gap_flags;
    logic [ADDR_BITS-1:0] gap_base, gap_end;
    logic [ADDR_BITS-1:0] gap_kfirst, gap_klast, gap_bfirst, gap_blast;

    // fit -> report
    logic                 hit_valid, hit_ready;
    rgrp_hit_t            hit;
    logic [ADDR_BITS-1:0] hit_addr;

    // input register, saturated region end, overlap and clipping
    rgrp_gaps #(
        .ADDR_BITS(ADDR_BITS)
    ) u_gaps (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_region_base  (s_region_base),
        .s_region_length(s_region_length),
        .s_region_kind  (s_region_kind),
        .s_last_region  (s_last_region),
        .kernel_first   (kernel_first_reg),
        .kernel_last    (kernel_last_reg),
        .boot_info_first(boot_info_first_reg),
        .boot_info_last (boot_info_last_reg),
        .low_limit      (low_limit_reg),
        .out_valid      (gap_valid),
        .out_ready      (gap_ready),
        .out_flags      (gap_flags),
        .out_start      (gap_base),
        .out_end        (gap_end),
        .out_kfirst     (gap_kfirst),
        .out_klast      (gap_klast),
        .out_bfirst     (gap_bfirst),
        .out_blast      (gap_blast)
    );

    // below, between and above the gaps, first fit wins
    rgrp_fit #(
        .ADDR_BITS  (ADDR_BITS),
        .FRAME_SHIFT(FRAME_SHIFT)
    ) u_fit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (gap_valid),
        .in_ready (gap_ready),
        .in_flags (gap_flags),
        .in_start (gap_base),
        .in_end   (gap_end),
        .in_kfirst(gap_kfirst),
        .in_klast (gap_klast),
        .in_bfirst(gap_bfirst),
        .in_blast (gap_blast),
        .req_size (request_size_reg),
        .out_valid(hit_valid),
        .out_ready(hit_ready),
        .out_hit  (hit),
        .out_addr (hit_addr)
    );

    // first placement of the map is latched and reported on the final region
    rgrp_report #(
        .ADDR_BITS  (ADDR_BITS),
        .FRAME_SHIFT(FRAME_SHIFT)
    ) u_report (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (hit_valid),
        .in_ready       (hit_ready),
        .in_hit         (hit),
        .in_addr        (hit_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_place_found  (m_place_found),
        .m_place_address(m_place_address)
    );

endmodule
